/* design/multi_channel_led_blinker_unit_macros.svh */
// Assertion macros used by the LED blinker controller.
`ifndef MULTI_CHANNEL_LED_BLINKER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_LED_BLINKER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCLB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mclb_pkg.sv */
// Package with the types and constants of the LED blinker.
`default_nettype none
package mclb_pkg;

  localparam int CHANNELS = 32;
  localparam int IDX_W    = $clog2(CHANNELS);
  localparam int NUM_W    = 6;
  localparam int CNT_W    = $clog2(CHANNELS + 1);

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_SOLID = 3'd1,
    OP_BLINK = 3'd2,
    OP_RATE  = 3'd3,
    OP_QUERY = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ON      = 3'd1,
    EV_OFF     = 3'd2,
    EV_STARTED = 3'd3,
    EV_DONE    = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ON      = 2'd1,
    MODE_BLINK   = 2'd2,
    MODE_ONESHOT = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    REG_NUM_LEDS = 1'b0,
    REG_POLARITY = 1'b1
  } reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_tick;
    logic accept_cmd;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic emit_end;
  } dp_status_t;

endpackage
`default_nettype wire

/* design/multi_channel_led_blinker_unit.sv */
// Top level of the multi-channel LED blinker.
//
//  Channel   Handshake                 Payload
//  input     start / busy              op_i led_i level_i on_time_i off_time_i repeats_i
//  result    result_valid_o (strobe)   event_*_o pin_levels_o mode_o last_o
//  config    cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// A command's result is registered and appears on the following cycle.
// A tick scans every channel entry with one shared update unit, then walks
// the finished list.
// Configuration writes are held off while a tick is being processed.
// Reset is asynchronous and active low; no clearing pass follows it.
// The receiver cannot stall: each result is strobed for a single cycle.
`default_nettype none
module multi_channel_led_blinker_unit
  import mclb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  op_i,
  input  wire logic [4:0]  led_i,
  input  wire logic        level_i,
  input  wire logic [15:0] on_time_i,
  input  wire logic [15:0] off_time_i,
  input  wire logic [7:0]  repeats_i,
  output logic             result_valid_o,
  output logic [2:0]       event_kind_o,
  output logic [4:0]       event_led_o,
  output logic             event_level_o,
  output logic [15:0]      event_on_time_o,
  output logic [15:0]      event_off_time_o,
  output logic [7:0]       event_repeats_o,
  output logic [31:0]      event_time_o,
  output logic [31:0]      pin_levels_o,
  output logic [1:0]       mode_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = !busy;

  mclb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  mclb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .led_i            (led_i),
    .level_i          (level_i),
    .on_time_i        (on_time_i),
    .off_time_i       (off_time_i),
    .repeats_i        (repeats_i),
    .res_valid_o      (result_valid_o),
    .event_kind_o     (event_kind_o),
    .event_led_o      (event_led_o),
    .event_level_o    (event_level_o),
    .event_on_time_o  (event_on_time_o),
    .event_off_time_o (event_off_time_o),
    .event_repeats_o  (event_repeats_o),
    .event_time_o     (event_time_o),
    .pin_levels_o     (pin_levels_o),
    .mode_o           (mode_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

/* design/mclb_ctrl.sv */
// Controller state machine of the LED blinker.
`default_nettype none
`include "multi_channel_led_blinker_unit_macros.svh"
module mclb_ctrl
  import mclb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [2:0] op_i,
  input  dp_status_t      status_i,
  output ctrl_cmd_t       cmd_o,
  output logic            busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    cmd_o.accept_tick = accept && (op_e'(op_i) == OP_TICK);
    cmd_o.accept_cmd  = accept && (op_e'(op_i) != OP_TICK);
    cmd_o.scan        = (state_q == ST_SCAN);
    cmd_o.emit        = (state_q == ST_EMIT);
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept_tick) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (status_i.scan_last) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status_i.emit_end) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `MCLB_ASSERT_NEXT(a_tick_scans, clk_i, rst_ni, cmd_o.accept_tick, state_q == ST_SCAN,
                    "tick transaction did not start a scan")
  `MCLB_ASSERT_NEXT(a_scan_runs, clk_i, rst_ni, state_q == ST_SCAN && !status_i.scan_last,
                    state_q == ST_SCAN, "scan ended early")
  `MCLB_ASSERT_NEXT(a_emit_ends, clk_i, rst_ni, state_q == ST_EMIT && status_i.emit_end,
                    state_q == ST_IDLE && !busy, "emission did not return to idle")

endmodule
`default_nettype wire

/* design/mclb_dp.sv */
// Datapath of the LED blinker: channel state, time counter and result register.
`default_nettype none
module mclb_dp
  import mclb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [2:0]  op_i,
  input  wire logic [4:0]  led_i,
  input  wire logic        level_i,
  input  wire logic [15:0] on_time_i,
  input  wire logic [15:0] off_time_i,
  input  wire logic [7:0]  repeats_i,
  output logic             res_valid_o,
  output logic [2:0]       event_kind_o,
  output logic [4:0]       event_led_o,
  output logic             event_level_o,
  output logic [15:0]      event_on_time_o,
  output logic [15:0]      event_off_time_o,
  output logic [7:0]       event_repeats_o,
  output logic [31:0]      event_time_o,
  output logic [31:0]      pin_levels_o,
  output logic [1:0]       mode_o,
  output logic             last_o
);

  localparam logic [NUM_W-1:0] CH_N  = NUM_W'(CHANNELS);
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(CHANNELS - 1);

  // Control state.
  logic [NUM_W-1:0]    num_q, num_d;
  logic [31:0]         pol_q, pol_d;
  logic [31:0]         now_q, now_d;
  mode_e               chmode_q [CHANNELS];
  mode_e               chmode_d [CHANNELS];
  logic [CHANNELS-1:0] lon_q, lon_d;
  logic [CHANNELS-1:0] ph_q, ph_d;
  logic [CHANNELS-1:0] done_q, done_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    emitted_q, emitted_d;
  logic                valid_q, valid_d;

  // Channel payload.
  logic [15:0] onl_q [CHANNELS];
  logic [15:0] onl_d [CHANNELS];
  logic [15:0] offl_q [CHANNELS];
  logic [15:0] offl_d [CHANNELS];
  logic [7:0]  left_q [CHANNELS];
  logic [7:0]  left_d [CHANNELS];
  logic [31:0] pend_q [CHANNELS];
  logic [31:0] pend_d [CHANNELS];

  // Result register.
  event_e      kind_q, kind_d;
  logic [4:0]  rled_q, rled_d;
  logic        rlvl_q, rlvl_d;
  logic [15:0] ront_q, ront_d;
  logic [15:0] rofft_q, rofft_d;
  logic [7:0]  rrep_q, rrep_d;
  logic [31:0] rtime_q, rtime_d;
  logic [31:0] rpins_q, rpins_d;
  mode_e       rmode_q, rmode_d;
  logic        rlast_q, rlast_d;

  logic [NUM_W-1:0] n_act;
  logic             led_ok;
  logic             scan_last;
  logic             emit_final;

  assign n_act      = (num_q > CH_N) ? CH_N : num_q;
  assign led_ok     = {1'b0, led_i} < n_act;
  assign scan_last  = (idx_q == IDX_END);
  assign emit_final = done_q[idx_q] && ((emitted_q + 1'b1) == cnt_q);

  assign status_o.scan_last = scan_last;
  assign status_o.emit_end  = (cnt_q == '0) || emit_final;

  always_comb begin
    logic       ph_new;
    logic [7:0] left_new;
    num_d     = num_q;
    pol_d     = pol_q;
    now_d     = now_q;
    chmode_d  = chmode_q;
    lon_d     = lon_q;
    ph_d      = ph_q;
    done_d    = done_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    emitted_d = emitted_q;
    onl_d     = onl_q;
    offl_d    = offl_q;
    left_d    = left_q;
    pend_d    = pend_q;
    valid_d   = 1'b0;
    kind_d    = kind_q;
    rled_d    = rled_q;
    rlvl_d    = rlvl_q;
    ront_d    = ront_q;
    rofft_d   = rofft_q;
    rrep_d    = rrep_q;
    rtime_d   = rtime_q;
    rpins_d   = rpins_q;
    rmode_d   = rmode_q;
    rlast_d   = rlast_q;
    ph_new    = 1'b0;
    left_new  = '0;

    if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_NUM_LEDS: num_d = cfg_data_i[NUM_W-1:0];
        REG_POLARITY: pol_d = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.accept_tick) begin
      now_d     = now_q + 32'd1;
      idx_d     = '0;
      cnt_d     = '0;
      emitted_d = '0;
      done_d    = '0;
    end

    if (cmd_i.accept_cmd) begin
      kind_d  = EV_NONE;
      rled_d  = led_i;
      rlvl_d  = 1'b0;
      ront_d  = '0;
      rofft_d = '0;
      rrep_d  = '0;
      rmode_d = MODE_OFF;
      rlast_d = 1'b1;
      rtime_d = now_q;
      valid_d = 1'b1;
      if (op_i > OP_QUERY) begin
        rled_d = '0;
      end else if (led_ok) begin
        unique case (op_e'(op_i))
          OP_SOLID: begin
            chmode_d[led_i] = level_i ? MODE_ON : MODE_OFF;
            lon_d[led_i]    = level_i;
            kind_d          = level_i ? EV_ON : EV_OFF;
            rlvl_d          = level_i;
          end
          OP_BLINK: begin
            chmode_d[led_i] = (repeats_i == '0) ? MODE_BLINK : MODE_ONESHOT;
            onl_d[led_i]    = on_time_i;
            offl_d[led_i]   = off_time_i;
            left_d[led_i]   = repeats_i;
            ph_d[led_i]     = 1'b1;
            lon_d[led_i]    = 1'b1;
            pend_d[led_i]   = now_q + {16'd0, on_time_i};
            kind_d          = EV_STARTED;
            rlvl_d          = 1'b1;
            ront_d          = on_time_i;
            rofft_d         = off_time_i;
            rrep_d          = repeats_i;
          end
          OP_RATE: begin
            if (chmode_q[led_i] == MODE_BLINK || chmode_q[led_i] == MODE_ONESHOT) begin
              onl_d[led_i]  = on_time_i;
              offl_d[led_i] = off_time_i;
            end
            rlvl_d = lon_q[led_i];
          end
          OP_QUERY: begin
            rlvl_d  = lon_q[led_i];
            rmode_d = chmode_q[led_i];
          end
          default: ;
        endcase
      end
      rpins_d = ~(lon_d ^ pol_q);
    end

    if (cmd_i.scan) begin
      idx_d = scan_last ? '0 : idx_q + 1'b1;
      if (({1'b0, idx_q} < n_act)
          && (chmode_q[idx_q] == MODE_BLINK || chmode_q[idx_q] == MODE_ONESHOT)
          && (now_q >= pend_q[idx_q])) begin
        ph_new        = ~ph_q[idx_q];
        ph_d[idx_q]   = ph_new;
        lon_d[idx_q]  = ph_new;
        pend_d[idx_q] = now_q + {16'd0, (ph_new ? onl_q[idx_q] : offl_q[idx_q])};
        if (!ph_new && chmode_q[idx_q] == MODE_ONESHOT) begin
          left_new      = (left_q[idx_q] != '0) ? left_q[idx_q] - 8'd1 : '0;
          left_d[idx_q] = left_new;
          if (left_new == '0) begin
            chmode_d[idx_q] = MODE_OFF;
            lon_d[idx_q]    = 1'b0;
            done_d[idx_q]   = 1'b1;
            cnt_d           = cnt_q + 1'b1;
          end
        end
      end
    end

    if (cmd_i.emit) begin
      idx_d = idx_q + 1'b1;
      // Pin levels are final once the scan is over, so every event reports them.
      if (cnt_q == '0 || done_q[idx_q]) begin
        valid_d   = 1'b1;
        kind_d    = (cnt_q == '0) ? EV_NONE : EV_DONE;
        rled_d    = (cnt_q == '0) ? '0 : 5'(idx_q);
        rlvl_d    = 1'b0;
        ront_d    = '0;
        rofft_d   = '0;
        rrep_d    = '0;
        rmode_d   = MODE_OFF;
        rtime_d   = now_q;
        rpins_d   = ~(lon_q ^ pol_q);
        rlast_d   = (cnt_q == '0) || emit_final;
        emitted_d = emitted_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q     <= '0;
      pol_q     <= '1;
      now_q     <= '0;
      lon_q     <= '0;
      ph_q      <= '0;
      done_q    <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      emitted_q <= '0;
      valid_q   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chmode_q[i] <= MODE_OFF;
      end
    end else begin
      num_q     <= num_d;
      pol_q     <= pol_d;
      now_q     <= now_d;
      lon_q     <= lon_d;
      ph_q      <= ph_d;
      done_q    <= done_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      emitted_q <= emitted_d;
      valid_q   <= valid_d;
      chmode_q  <= chmode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    onl_q   <= onl_d;
    offl_q  <= offl_d;
    left_q  <= left_d;
    pend_q  <= pend_d;
    kind_q  <= kind_d;
    rled_q  <= rled_d;
    rlvl_q  <= rlvl_d;
    ront_q  <= ront_d;
    rofft_q <= rofft_d;
    rrep_q  <= rrep_d;
    rtime_q <= rtime_d;
    rpins_q <= rpins_d;
    rmode_q <= rmode_d;
    rlast_q <= rlast_d;
  end

  assign res_valid_o      = valid_q;
  assign event_kind_o     = kind_q;
  assign event_led_o      = rled_q;
  assign event_level_o    = rlvl_q;
  assign event_on_time_o  = ront_q;
  assign event_off_time_o = rofft_q;
  assign event_repeats_o  = rrep_q;
  assign event_time_o     = rtime_q;
  assign pin_levels_o     = rpins_q;
  assign mode_o           = rmode_q;
  assign last_o           = rlast_q;

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the multi-channel LED blinker unit.
`timescale 1ns / 100ps
module tb_top;
  import mclb_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  led;
    logic        level;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [7:0]  repeats;
  } command_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  led;
    logic        level;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [7:0]  repeats;
    logic [31:0] stamp;
    logic [31:0] pins;
    logic [1:0]  mode;
    logic        last;
  } led_event_t;

  logic clk_i, rst_ni, start, busy;
  logic [2:0] op_i;
  logic [4:0] led_i;
  logic level_i;
  logic [15:0] on_time_i, off_time_i;
  logic [7:0] repeats_i;
  logic result_valid_o;
  logic [2:0] event_kind_o;
  logic [4:0] event_led_o;
  logic event_level_o;
  logic [15:0] event_on_time_o, event_off_time_o;
  logic [7:0] event_repeats_o;
  logic [31:0] event_time_o, pin_levels_o;
  logic [1:0] mode_o;
  logic last_o;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0] cfg_data_i;

  multi_channel_led_blinker_unit dut (.*);

  // Shadow copy of the block's registers and channel table.
  logic [5:0]  led_count;
  logic [31:0] pol_mask;
  logic [31:0] tick_count;
  mode_e       chan_mode  [32];
  logic        chan_lit   [32];
  logic        chan_phase [32];
  logic [15:0] chan_on    [32];
  logic [15:0] chan_off   [32];
  logic [7:0]  chan_left  [32];
  logic [31:0] chan_due   [32];

  led_event_t pending_events[$];
  int mismatches = 0;
  int items_sent = 0;
  int events_seen = 0;
  int done_seen = 0;
  int burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("multi_channel_led_blinker_unit test failed");
    $finish;
  end

  function automatic led_event_t make_event(logic [2:0] kind, logic [4:0] led, logic lvl,
                                            logic [15:0] ont, logic [15:0] offt,
                                            logic [7:0] rep, logic [1:0] md);
    led_event_t ev;
    ev = '{kind, led, lvl, ont, offt, rep, tick_count, 32'd0, md, 1'b0};
    return ev;
  endfunction

  // Applies one accepted item to the shadow state and queues its events.
  function automatic void predict_led_events(command_t c);
    led_event_t batch[$];
    logic [31:0] lit_bits;
    int active;
    active = (led_count < 32) ? led_count : 32;
    if (c.op == OP_TICK) begin
      tick_count = tick_count + 1;
      for (int i = 0; i < active; i++) begin
        if (chan_mode[i] != MODE_BLINK && chan_mode[i] != MODE_ONESHOT) continue;
        if (tick_count < chan_due[i]) continue;
        chan_phase[i] = ~chan_phase[i];
        chan_lit[i] = chan_phase[i];
        chan_due[i] = tick_count + (chan_phase[i] ? chan_on[i] : chan_off[i]);
        if (!chan_phase[i] && chan_mode[i] == MODE_ONESHOT) begin
          if (chan_left[i] > 0) chan_left[i]--;
          if (chan_left[i] == 0) begin
            chan_mode[i] = MODE_OFF;
            chan_lit[i] = 1'b0;
            batch.push_back(make_event(EV_DONE, i[4:0], 1'b0, 0, 0, 0, MODE_OFF));
          end
        end
      end
      if (batch.size() == 0) batch.push_back(make_event(EV_NONE, 0, 0, 0, 0, 0, MODE_OFF));
    end else if (c.op > OP_QUERY) begin
      batch.push_back(make_event(EV_NONE, 0, 0, 0, 0, 0, MODE_OFF));
    end else if (c.led >= active) begin
      batch.push_back(make_event(EV_NONE, c.led, 0, 0, 0, 0, MODE_OFF));
    end else begin
      case (c.op)
        OP_SOLID: begin
          chan_mode[c.led] = c.level ? MODE_ON : MODE_OFF;
          chan_lit[c.led] = c.level;
          batch.push_back(make_event(c.level ? EV_ON : EV_OFF, c.led, c.level,
                                     0, 0, 0, MODE_OFF));
        end
        OP_BLINK: begin
          chan_mode[c.led] = (c.repeats == 0) ? MODE_BLINK : MODE_ONESHOT;
          chan_on[c.led] = c.on_time;
          chan_off[c.led] = c.off_time;
          chan_left[c.led] = c.repeats;
          chan_phase[c.led] = 1'b1;
          chan_lit[c.led] = 1'b1;
          chan_due[c.led] = tick_count + c.on_time;
          batch.push_back(make_event(EV_STARTED, c.led, 1'b1, c.on_time, c.off_time,
                                     c.repeats, MODE_OFF));
        end
        OP_RATE: begin
          if (chan_mode[c.led] == MODE_BLINK || chan_mode[c.led] == MODE_ONESHOT) begin
            chan_on[c.led] = c.on_time;
            chan_off[c.led] = c.off_time;
          end
          batch.push_back(make_event(EV_NONE, c.led, chan_lit[c.led], 0, 0, 0, MODE_OFF));
        end
        default: begin
          batch.push_back(make_event(EV_NONE, c.led, chan_lit[c.led], 0, 0, 0,
                                     chan_mode[c.led]));
        end
      endcase
    end
    for (int i = 0; i < 32; i++) lit_bits[i] = chan_lit[i];
    foreach (batch[j]) begin
      batch[j].pins = ~(lit_bits ^ pol_mask);
      batch[j].last = (j == batch.size() - 1);
      pending_events.push_back(batch[j]);
    end
  endfunction

  // Result monitor: every strobed result must match the oldest prediction.
  always @(posedge clk_i) begin
    led_event_t seen, want;
    if (rst_ni && result_valid_o) begin
      seen = '{event_kind_o, event_led_o, event_level_o, event_on_time_o,
               event_off_time_o, event_repeats_o, event_time_o, pin_levels_o,
               mode_o, last_o};
      events_seen++;
      if (seen.kind == EV_DONE) done_seen++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", seen);
      end else begin
        want = pending_events.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, seen);
        end
      end
    end
  end

  // Sends one item; start stays high across a burst and drops only in gaps.
  task automatic send_item(command_t c);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start <= 1'b1;
    {op_i, led_i, level_i, on_time_i, off_time_i, repeats_i} <= c;
    do @(posedge clk_i); while (busy);
    predict_led_events(c);
    items_sent++;
  endtask

  task automatic send_cmd(logic [2:0] op, logic [4:0] led, logic lvl = 0,
                          logic [15:0] ont = 0, logic [15:0] offt = 0, logic [7:0] rep = 0);
    send_item('{op, led, lvl, ont, offt, rep});
  endtask

  // Waits until every outstanding result has arrived and the block is quiet.
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_NUM_LEDS) led_count = data[5:0];
    else pol_mask = data;
  endtask

  task automatic test_unregistered();
    send_cmd(OP_SOLID, 5'd0, 1'b1);
    send_cmd(OP_QUERY, 5'd31);
    send_cmd(OP_TICK, 5'd0);
  endtask

  task automatic test_solid_and_query();
    write_reg(REG_NUM_LEDS, 32'd4);
    send_cmd(OP_SOLID, 5'd1, 1'b1);
    send_cmd(OP_QUERY, 5'd1);
    send_cmd(OP_SOLID, 5'd1, 1'b0);
    send_cmd(OP_SOLID, 5'd4, 1'b1);
    // Rate change on a channel that is not blinking leaves it alone.
    send_cmd(OP_RATE, 5'd2, 1'b0, 16'hFFFF, 16'hFFFF);
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) send_cmd(op[2:0], 5'd31, 1'b1);
  endtask

  task automatic test_blink_patterns();
    send_cmd(OP_BLINK, 5'd0, 1'b0, 16'd1, 16'd1, 8'd0);
    send_cmd(OP_BLINK, 5'd2, 1'b0, 16'd0, 16'd0, 8'd1);
    send_cmd(OP_BLINK, 5'd3, 1'b0, 16'd2, 16'd1, 8'd2);
    send_cmd(OP_BLINK, 5'd1, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_cmd(OP_RATE, 5'd0, 1'b0, 16'd0, 16'd2);
    send_cmd(OP_QUERY, 5'd3);
    repeat (8) send_cmd(OP_TICK, 5'd0);
  endtask

  task automatic test_polarity_and_limits();
    write_reg(REG_POLARITY, 32'h0);
    write_reg(REG_NUM_LEDS, 32'd63);
    send_cmd(OP_SOLID, 5'd31, 1'b1);
    send_cmd(OP_TICK, 5'd0);
    write_reg(REG_POLARITY, 32'hA5A5_5A5A);
    send_cmd(OP_QUERY, 5'd31);
  endtask

  task automatic test_random_traffic();
    logic [5:0] sizes[5] = '{6'd32, 6'd1, 6'd0, 6'd17, 6'd63};
    command_t c;
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_NUM_LEDS, {26'd0, sizes[p]});
      write_reg(REG_POLARITY, $urandom());
      repeat (56) begin
        c = '{3'($urandom_range(0, 4)), 5'($urandom()), 1'($urandom()),
              16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
              8'($urandom_range(0, 3))};
        // Mostly ticks and short patterns, with the odd full-width field.
        if ($urandom_range(0, 9) < 5) c.op = OP_TICK;
        if ($urandom_range(0, 9) == 0) c.on_time = 16'($urandom());
        if ($urandom_range(0, 9) == 0) c.off_time = 16'($urandom());
        if ($urandom_range(0, 9) == 0) c.repeats = 8'($urandom());
        if ($urandom_range(0, 29) == 0) c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        send_item(c);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    {op_i, led_i, level_i, on_time_i, off_time_i, repeats_i} = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    led_count = '0;
    pol_mask = '1;
    tick_count = '0;
    for (int i = 0; i < 32; i++) begin
      chan_mode[i] = MODE_OFF;
      {chan_lit[i], chan_phase[i], chan_on[i], chan_off[i], chan_left[i], chan_due[i]} = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unregistered();
    test_solid_and_query();
    test_blink_patterns();
    test_polarity_and_limits();
    test_random_traffic();
    drain();

    $display("Sent %0d items over several channel counts and polarity masks.", items_sent);
    $display("Checked %0d results, %0d of them pattern-done events; %0d mismatches.",
             events_seen, done_seen, mismatches);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("multi_channel_led_blinker_unit test passed");
    end else begin
      $display("multi_channel_led_blinker_unit test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/mclb_pkg.sv
design/mclb_ctrl.sv
design/mclb_dp.sv
design/multi_channel_led_blinker_unit.sv
test/tb_top.sv
